// ===== hw/rtl/playfair_digraph_encrypt_unit_macros.svh =====
// Assertion macros for the Playfair digraph encryption unit.
// Included by the top level; needs clk and rst in the including scope.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_UNIT_MACROS_SVH

// Condition in the same cycle implies a consequence in the same cycle.
`define PFE_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define PFE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfe_pkg.sv =====
// Shared types, constants and helpers for the Playfair digraph encryption unit.
// No dependencies.
package pfe_pkg;

  localparam int DIM    = 5;
  localparam int CODE_W = 5;
  localparam int ROW_W  = DIM * CODE_W;
  localparam int IDX_W  = 3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ROW_W-1:0]  row_t;

  // Square as cells: [row][column]
  typedef code_t [DIM-1:0][DIM-1:0] square_t;

  localparam code_t CODE_I = code_t'(8);
  localparam code_t CODE_J = code_t'(9);

  // Register indexes on the configuration port
  localparam idx_t REG_ROW_0 = idx_t'(0);

  localparam row_t ROW_RESET [DIM] = '{
    row_t'(4294688), row_t'(10755269), row_t'(16201099),
    row_t'(21613104), row_t'(27025109)
  };

  // Position of a letter in the square
  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } loc_t;

  // Step one place on, wrapping at the square edge
  function automatic idx_t wrap_inc(idx_t i);
    wrap_inc = (i == idx_t'(DIM - 1)) ? '0 : i + idx_t'(1);
  endfunction

endpackage

// ===== hw/rtl/playfair_digraph_encrypt_unit.sv =====
// Playfair digraph encryption unit: an accepted pair goes to the input register and then
// to the result register. Throughput one letter pair per cycle; the two-stage pipeline
// advances whenever the result register is empty or being taken, so a pair is accepted
// every clock unless both stages are full and the result is not taken. Synchronous
// active-high reset empties both stages and loads the default square (A..Z without J in
// row order). Depends on pfe_pkg, pfe_locate, pfe_cipher_select and the macros header.
`include "playfair_digraph_encrypt_unit_macros.svh"

module playfair_digraph_encrypt_unit import pfe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  // configuration write port
  input  logic  cfg_write,
  input  idx_t  cfg_index,
  input  row_t  cfg_data,
  // letter pair in
  input  logic  in_valid,
  output logic  in_ready,
  input  code_t first_letter,
  input  code_t second_letter,
  // cipher pair out
  output logic  out_valid,
  input  logic  out_ready,
  output code_t first_cipher,
  output code_t second_cipher,
  output logic  not_found
);

  // Key square row registers
  row_t square_row [DIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        square_row[r] <= ROW_RESET[r];
      end
    end else if (cfg_write) begin
      // Drop writes to indexes past the last row
      for (int r = 0; r < DIM; r++) begin
        if (cfg_index == REG_ROW_0 + idx_t'(r)) begin
          square_row[r] <= cfg_data;
        end
      end
    end
  end

  // Unpack rows into cells, column 0 in the low bits
  square_t square;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        square[r][c] = square_row[r][c*CODE_W +: CODE_W];
      end
    end
  end

  // Stage 1: input register
  logic  stage_valid;
  code_t stage_a;
  code_t stage_b;
  logic  out_free;
  logic  stage_move;

  // Result register can load when empty or when its contents transfer now
  assign out_free   = !out_valid || out_ready;
  assign stage_move = stage_valid && out_free;
  assign in_ready   = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    // Hold the pair until the next transfer
    if (in_valid && in_ready) begin
      stage_a <= first_letter;
      stage_b <= second_letter;
    end
  end

  // Locate both letters and pick the cipher letters
  loc_t  loc_a;
  loc_t  loc_b;
  code_t cipher_a;
  code_t cipher_b;
  logic  missing;

  pfe_locate u_locate_a (
    .square (square),
    .letter (stage_a),
    .loc    (loc_a)
  );

  pfe_locate u_locate_b (
    .square (square),
    .letter (stage_b),
    .loc    (loc_b)
  );

  pfe_cipher_select u_select (
    .square   (square),
    .loc_a    (loc_a),
    .loc_b    (loc_b),
    .cipher_a (cipher_a),
    .cipher_b (cipher_b),
    .missing  (missing)
  );

  // Stage 2: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
    if (stage_move) begin
      first_cipher  <= cipher_a;
      second_cipher <= cipher_b;
      not_found     <= missing;
    end
  end

  // Checks
  `PFE_ASSERT_SAME(a_missing_zero, out_valid && not_found,
    first_cipher == '0 && second_cipher == '0, "absent letter with non-zero cipher")
  `PFE_ASSERT_NEXT(a_in_to_stage, in_valid && in_ready, stage_valid,
    "accepted pair not held in input register")
  `PFE_ASSERT_NEXT(a_stage_to_out, stage_move, out_valid,
    "advanced pair not shown as result")
  `PFE_ASSERT_SAME(a_stall_full, !in_ready,
    stage_valid && out_valid && !out_ready, "input stalled while pipeline not full")

endmodule

// ===== hw/rtl/pfe_locate.sv =====
// Finds one letter in the key square, first match in row-major order.
// Depends on pfe_pkg.
module pfe_locate import pfe_pkg::*; (
  input  square_t square,
  input  code_t   letter,
  output loc_t    loc
);

  code_t key;

  // J shares a cell with I
  assign key = (letter == CODE_J) ? CODE_I : letter;

  // Scan from the last cell back so the earliest match overrides
  always_comb begin
    loc = '0;
    for (int r = DIM - 1; r >= 0; r--) begin
      for (int c = DIM - 1; c >= 0; c--) begin
        if (square[r][c] == key) begin
          loc.found = 1'b1;
          loc.row   = idx_t'(r);
          loc.col   = idx_t'(c);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/pfe_cipher_select.sv =====
// Applies the same-row, same-column and rectangle rules to two located letters.
// Depends on pfe_pkg.
module pfe_cipher_select import pfe_pkg::*; (
  input  square_t square,
  input  loc_t    loc_a,
  input  loc_t    loc_b,
  output code_t   cipher_a,
  output code_t   cipher_b,
  output logic    missing
);

  idx_t ra, ca, rb, cb;

  always_comb begin
    ra = loc_a.row;
    ca = loc_a.col;
    rb = loc_b.row;
    cb = loc_b.col;
    if (loc_a.row == loc_b.row) begin
      ca = wrap_inc(loc_a.col);
      cb = wrap_inc(loc_b.col);
    end else if (loc_a.col == loc_b.col) begin
      ra = wrap_inc(loc_a.row);
      rb = wrap_inc(loc_b.row);
    end else begin
      ca = loc_b.col;
      cb = loc_a.col;
    end
  end

  assign missing  = !(loc_a.found && loc_b.found);
  assign cipher_a = missing ? '0 : square[ra][ca];
  assign cipher_b = missing ? '0 : square[rb][cb];

endmodule

// ===== tb/playfair_digraph_encrypt_unit_tb.sv =====
// Self-checking testbench for the Playfair digraph encryption unit.
// Holds its own Playfair predictor and key square copy; depends on pfe_pkg and the RTL top level.
`timescale 1ns / 100ps

module playfair_digraph_encrypt_unit_tb;
  import pfe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 17;
  localparam int PAIRS_PER_PHASE = 100;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {
    SQ_DEFAULT,
    SQ_ZERO,
    SQ_ONES,
    SQ_SHUFFLED,
    SQ_ODD_CODES,
    SQ_REPEATS,
    SQ_RAW
  } square_kind_t;

  typedef struct packed {
    code_t first;
    code_t second;
  } letter_pair_t;

  typedef struct packed {
    code_t first;
    code_t second;
    logic  absent;
  } cipher_pair_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_write = 1'b0;
  idx_t  cfg_index = '0;
  row_t  cfg_data = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  code_t first_letter = '0;
  code_t second_letter = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  code_t first_cipher;
  code_t second_cipher;
  logic  not_found;

  // Testbench copy of the key square, one packed row per register
  row_t key_rows [DIM];

  letter_pair_t pending_pairs [$];
  cipher_pair_t expected_ciphers [$];
  letter_pair_t next_pair;
  cipher_pair_t want_cipher;

  logic pair_taken = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   rx_hold_left = 0;
  int   cycle_count = 0;
  int   fail_count = 0;

  playfair_digraph_encrypt_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_letter (first_letter),
    .second_letter(second_letter),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_cipher (first_cipher),
    .second_cipher(second_cipher),
    .not_found    (not_found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------

  function automatic code_t key_cell(int r, int c);
    return key_rows[r][CODE_W*c +: CODE_W];
  endfunction

  // Find a letter in the square, J folded onto I; the first match in
  // row-major order wins.
  function automatic loc_t find_letter(code_t letter);
    loc_t  where;
    code_t want;
    where = '0;
    want = (letter == CODE_J) ? CODE_I : letter;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        if (!where.found && key_cell(r, c) == want) begin
          where.found = 1'b1;
          where.row = idx_t'(r);
          where.col = idx_t'(c);
        end
      end
    end
    return where;
  endfunction

  function automatic cipher_pair_t encrypt_pair(code_t a, code_t b);
    loc_t         pa;
    loc_t         pb;
    cipher_pair_t res;
    int           r1, c1, r2, c2;
    pa = find_letter(a);
    pb = find_letter(b);
    res = '0;
    r1 = int'(pa.row);
    c1 = int'(pa.col);
    r2 = int'(pb.row);
    c2 = int'(pb.col);
    if (!pa.found || !pb.found) begin
      // Either letter missing: flag it and zero both letters
      res.absent = 1'b1;
    end else if (r1 == r2) begin
      // Same row, doubled letters included: step right with wrap
      res.first = key_cell(r1, (c1 + 1) % DIM);
      res.second = key_cell(r2, (c2 + 1) % DIM);
    end else if (c1 == c2) begin
      // Same column: step down with wrap
      res.first = key_cell((r1 + 1) % DIM, c1);
      res.second = key_cell((r2 + 1) % DIM, c2);
    end else begin
      // Rectangle: swap the columns
      res.first = key_cell(r1, c2);
      res.second = key_cell(r2, c1);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Sample both transfers at the rising edge. Record the input transfer for
  // the driver, predict it, then check any output transfer against the
  // oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pair_taken = 1'b0;
    end else begin
      pair_taken = in_valid && in_ready;
      if (pair_taken)
        expected_ciphers.push_back(encrypt_pair(first_letter, second_letter));
      if (out_valid && out_ready) begin
        if (expected_ciphers.size() == 0) begin
          report_mismatch("result with nothing pending", first_cipher, -1);
        end else begin
          want_cipher = expected_ciphers.pop_front();
          if (first_cipher !== want_cipher.first)
            report_mismatch("first_cipher", first_cipher, want_cipher.first);
          if (second_cipher !== want_cipher.second)
            report_mismatch("second_cipher", second_cipher, want_cipher.second);
          if (not_found !== want_cipher.absent)
            report_mismatch("not_found", not_found, want_cipher.absent);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Driver and receiver
  // ---------------------------------------------------------------

  // Hold valid and payload until the transfer; only then offer the next
  // pair or go idle, so valid is never dropped and raised in one step.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pair_taken) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_pair = pending_pairs.pop_front();
        in_valid <= 1'b1;
        first_letter <= next_pair.first;
        second_letter <= next_pair.second;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off while the counter runs
  always @(negedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Count the long hold-off down, one per cycle
  always @(posedge clk) begin
    if (rx_hold_left > 0)
      rx_hold_left = rx_hold_left - 1;
  end

  // ---------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------

  task automatic push_pair(input int a, input int b);
    letter_pair_t p;
    p.first = code_t'(a);
    p.second = code_t'(b);
    pending_pairs.push_back(p);
  endtask

  // Mostly letters from A..Z; the rest from the whole 5-bit range
  function automatic code_t random_letter(int wide_pct);
    if ($urandom_range(99) < wide_pct)
      return code_t'($urandom_range(31));
    return code_t'($urandom_range(25));
  endfunction

  // Wait until no pair is queued, none is on offer and no result is owed
  task automatic wait_idle();
    while (pending_pairs.size() != 0 || in_valid || expected_ciphers.size() != 0)
      @(posedge clk);
  endtask

  // Build a square and write all five rows; call only while idle.
  // Returns just after a falling edge.
  task automatic load_square(input square_kind_t kind);
    int   pool [32];
    int   n;
    int   j;
    int   tmp;
    row_t rows [DIM];
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (kind == SQ_ODD_CODES || (i < 26 && i != int'(CODE_J))) begin
        pool[n] = i;
        n++;
      end
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int r = 0; r < DIM; r++) begin
      rows[r] = '0;
      case (kind)
        SQ_DEFAULT: rows[r] = ROW_RESET[r];
        SQ_ZERO:    rows[r] = '0;
        SQ_ONES:    rows[r] = '1;
        SQ_RAW:     rows[r] = row_t'($urandom);
        SQ_REPEATS: begin
          for (int c = 0; c < DIM; c++)
            rows[r][CODE_W*c +: CODE_W] = code_t'($urandom_range(25));
        end
        default: begin
          for (int c = 0; c < DIM; c++)
            rows[r][CODE_W*c +: CODE_W] = code_t'(pool[r*DIM + c]);
        end
      endcase
    end
    for (int r = 0; r < DIM; r++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= REG_ROW_0 + idx_t'(r);
      cfg_data <= rows[r];
      key_rows[r] = rows[r];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One random phase: new square, idling mode, and a drain half way so the
  // sender pauses until every result is back.
  task automatic run_phase(input square_kind_t kind, input int idle, input int stall,
                           input int hold, input int count);
    int wide_pct;
    wait_idle();
    load_square(kind);
    idle_pct = idle;
    stall_pct = stall;
    rx_hold_left = hold;
    wide_pct = (kind == SQ_SHUFFLED) ? 8 : 40;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        wait_idle();
      push_pair(random_letter(wide_pct), random_letter(wide_pct));
    end
    wait_idle();
  endtask

  initial begin
    square_kind_t kind;
    for (int r = 0; r < DIM; r++)
      key_rows[r] = ROW_RESET[r];

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default square straight out of reset: row rule with and without wrap,
    // doubled letters, column rule with wrap, rectangle, J folded onto I,
    // and codes outside the square.
    push_pair(0, 1);
    push_pair(3, 4);
    push_pair(4, 4);
    push_pair(0, 5);
    push_pair(0, 21);
    push_pair(0, 25);
    push_pair(25, 0);
    push_pair(9, 10);
    push_pair(9, 8);
    push_pair(9, 9);
    push_pair(25, 25);
    push_pair(7, 18);
    push_pair(12, 23);
    push_pair(15, 14);
    push_pair(26, 0);
    push_pair(0, 31);
    push_pair(31, 31);
    push_pair(26, 27);
    wait_idle();

    // All-zero square: only code 0 is present
    load_square(SQ_ZERO);
    push_pair(0, 0);
    push_pair(0, 1);
    push_pair(31, 0);
    wait_idle();

    // All-ones square: only code 31 is present
    load_square(SQ_ONES);
    push_pair(31, 31);
    push_pair(31, 0);
    push_pair(0, 0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 6)
        3:       kind = SQ_ODD_CODES;
        4:       kind = SQ_REPEATS;
        5:       kind = SQ_RAW;
        default: kind = SQ_SHUFFLED;
      endcase
      if (p == RANDOM_PHASES - 1)
        kind = SQ_DEFAULT;
      case (p % 4)
        0: run_phase(kind, 0, 0, (p == 4) ? LONG_HOLD : 0, PAIRS_PER_PHASE);
        1: run_phase(kind, 64, 0, 0, PAIRS_PER_PHASE);
        2: run_phase(kind, 0, 64, 0, PAIRS_PER_PHASE);
        default: run_phase(kind, 11, 11, 0, PAIRS_PER_PHASE);
      endcase
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_ciphers.size() != 0)
      report_mismatch("results still owed", expected_ciphers.size(), 0);

    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_locate.sv
hw/rtl/pfe_cipher_select.sv
hw/rtl/playfair_digraph_encrypt_unit.sv
tb/playfair_digraph_encrypt_unit_tb.sv
